// ===== design/fpl_pkg.sv =====
// shared constants and types for the four-pole ladder lowpass
// no dependencies
package fpl_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CUT_W    = 15;
    localparam int unsigned RES_W    = 16;
    localparam int unsigned SHIFT_Q  = 15;

    localparam logic [WORD_W-1:0] SCALE_ONE      = 32'd16383;
    localparam logic [WORD_W-1:0] POLE_PREV_GAIN = 32'h1333;
    localparam logic [WORD_W-1:0] CLIP_GAIN      = 32'h0AAB;
    localparam logic [WORD_W-1:0] F4_GAIN        = 32'h1668;
    localparam logic [WORD_W-1:0] FB_DAMP        = 32'h0999;

    // sequencer steps
    localparam logic [4:0] STEP_F2     = 5'd0;
    localparam logic [4:0] STEP_F2SQ   = 5'd1;
    localparam logic [4:0] STEP_F4     = 5'd2;
    localparam logic [4:0] STEP_DAMP   = 5'd3;
    localparam logic [4:0] STEP_FB     = 5'd4;
    localparam logic [4:0] STEP_FBK    = 5'd5;
    localparam logic [4:0] STEP_GAIN   = 5'd6;
    localparam logic [4:0] STEP_POLE0  = 5'd7;
    localparam logic [4:0] STEP_CLIP0  = 5'd15;
    localparam logic [4:0] STEP_CLIP1  = 5'd16;
    localparam logic [4:0] STEP_LAST   = 5'd17;

    localparam logic REG_CUTOFF = 1'b0;
    localparam logic REG_RES    = 1'b1;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

endpackage

// ===== design/fpl_mul.sv =====
// bit-serial shift-add multiplier, low 32 bits of the product
// depends on fpl_pkg
module fpl_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpl_pkg::t_mul_req             i_req,
    output logic                          o_done,
    output logic [fpl_pkg::WORD_W-1:0]    o_p
);
    logic [fpl_pkg::WORD_W-1:0] r_acc, r_mcand, r_mplier;
    logic [4:0] r_cnt;
    logic       r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mcand  <= i_req.a;
                r_mplier <= i_req.b;
            end else if (r_busy) begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= {r_mcand[fpl_pkg::WORD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[fpl_pkg::WORD_W-1:1]};
                r_cnt    <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

// ===== design/fpl_div.sv =====
// bit-serial restoring division by 16383, truncating toward zero
// depends on fpl_pkg
module fpl_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [fpl_pkg::WORD_W-1:0] i_num,
    output logic                              o_done,
    output logic signed [fpl_pkg::WORD_W-1:0] o_q
);
    logic [fpl_pkg::WORD_W-1:0] r_mag;
    logic [13:0] r_rem;
    logic [14:0] trial;
    logic [4:0]  r_cnt;
    logic        r_neg, r_busy, r_done;

    assign trial = {r_rem, r_mag[fpl_pkg::WORD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_neg  <= i_num[fpl_pkg::WORD_W-1];
                r_mag  <= i_num[fpl_pkg::WORD_W-1] ? (~i_num + 32'd1) : i_num;
            end else if (r_busy) begin
                if (trial >= fpl_pkg::SCALE_ONE[14:0]) begin
                    r_rem <= 14'(trial - fpl_pkg::SCALE_ONE[14:0]);
                    r_mag <= {r_mag[fpl_pkg::WORD_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[13:0];
                    r_mag <= {r_mag[fpl_pkg::WORD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed(r_mag) : $signed(r_mag);
endmodule

// ===== design/four_pole_ladder_lowpass_core.sv =====
// top level of the four-pole ladder lowpass: apb registers, sequencer, state
// depends on fpl_pkg, fpl_mul, fpl_div
//
// channel   dir  handshake                      payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready i_s_axis_tdata: sample_in[15:0]
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready o_m_axis_tdata: sample_out[15:0]
// apb       in   psel/penable/pwrite, pready=1   cutoff_coef @0, resonance @4
//
// one word takes 18 steps on a shared bit-serial multiplier (each step: start,
// the bit steps and the done cycle); 13 of them also run the serial divide by
// 16383, so the time per word is set by the serial units plus the accept and
// output-load cycles, and by any wait for the output register to free up
// reset clears the registers, the pole state and the output register
// a word is taken only while idle; a finished word waits in the output
// register and the next word can already be in work behind it
module four_pole_ladder_lowpass_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [fpl_pkg::SAMPLE_W-1:0]    i_s_axis_tdata,   // sample_in
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [fpl_pkg::SAMPLE_W-1:0]    o_m_axis_tdata,   // sample_out
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_WAIT, ST_DONE
    } t_state;

    t_state r_state;
    logic [4:0] r_step;
    logic [fpl_pkg::CUT_W-1:0] r_cut;
    logic [fpl_pkg::RES_W-1:0] r_res;

    // coefficient and scratch words
    logic [31:0] r_f2, r_f4, r_fb, r_t;
    logic signed [31:0] r_x, r_v, r_c;
    logic signed [31:0] r_out [4];
    logic signed [31:0] r_in  [4];

    logic r_out_valid;
    logic [fpl_pkg::SAMPLE_W-1:0] r_out_data;
    logic r_div_start;

    fpl_pkg::t_mul_req mul_req;
    logic        mul_done, div_done;
    logic [31:0] mul_p;
    logic signed [31:0] div_q;
    logic signed [31:0] fi, pole_sum;
    logic [2:0]  pole_off;
    logic [1:0]  k;
    logic        cfg_wr, out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == fpl_pkg::REG_RES) ? {16'd0, r_res} : {17'd0, r_cut};

    assign fi       = $signed(fpl_pkg::SCALE_ONE) - $signed({17'd0, r_cut});
    assign pole_off = 3'(r_step - fpl_pkg::STEP_POLE0);
    assign k        = pole_off[2:1];
    assign pole_sum = r_v + $signed(r_t) + div_q;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // operand select for the current step
    always_comb begin
        mul_req.start = (r_state == ST_MUL_GO);
        mul_req.a = '0;
        mul_req.b = '0;
        case (r_step)
            fpl_pkg::STEP_F2: begin
                mul_req.a = {17'd0, r_cut};  mul_req.b = {17'd0, r_cut};
            end
            fpl_pkg::STEP_F2SQ: begin
                mul_req.a = r_f2;  mul_req.b = r_f2;
            end
            fpl_pkg::STEP_F4: begin
                mul_req.a = fpl_pkg::F4_GAIN;  mul_req.b = r_t;
            end
            fpl_pkg::STEP_DAMP: begin
                mul_req.a = fpl_pkg::FB_DAMP;  mul_req.b = r_f2;
            end
            fpl_pkg::STEP_FB: begin
                mul_req.a = {16'd0, r_res};  mul_req.b = fpl_pkg::SCALE_ONE - r_t;
            end
            fpl_pkg::STEP_FBK: begin
                mul_req.a = r_out[3];  mul_req.b = r_fb;
            end
            fpl_pkg::STEP_GAIN: begin
                mul_req.a = r_v;  mul_req.b = r_f4;
            end
            fpl_pkg::STEP_CLIP0: begin
                mul_req.a = r_out[3];  mul_req.b = r_out[3];
            end
            fpl_pkg::STEP_CLIP1: begin
                mul_req.a = r_c;  mul_req.b = r_out[3];
            end
            fpl_pkg::STEP_LAST: begin
                mul_req.a = r_c;  mul_req.b = fpl_pkg::CLIP_GAIN;
            end
            default: begin
                // pole steps: even offset takes the previous input, odd the output
                if (pole_off[0]) begin
                    mul_req.a = fi;  mul_req.b = r_out[k];
                end else begin
                    mul_req.a = fpl_pkg::POLE_PREV_GAIN;  mul_req.b = r_in[k];
                end
            end
        endcase
    end

    fpl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    fpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (mul_p),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_cut       <= '0;
            r_res       <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_div_start <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_out[i] <= '0;
                r_in[i]  <= '0;
            end
        end else begin
            r_div_start <= 1'b0;
            if (cfg_wr) begin
                if (paddr[2] == fpl_pkg::REG_CUTOFF) r_cut <= pwdata[fpl_pkg::CUT_W-1:0];
                else                                 r_res <= pwdata[fpl_pkg::RES_W-1:0];
            end
            if (r_out_valid && i_m_axis_tready) r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_x     <= 32'(signed'(i_s_axis_tdata));
                        r_step  <= fpl_pkg::STEP_F2;
                        r_state <= ST_MUL_GO;
                    end
                end
                ST_MUL_GO: r_state <= ST_MUL_WAIT;
                ST_MUL_WAIT: begin
                    if (mul_done) begin
                        if (r_step < fpl_pkg::STEP_FBK) begin
                            // coefficient steps: plain shift by 15
                            case (r_step)
                                fpl_pkg::STEP_F2: r_f2 <= mul_p >> fpl_pkg::SHIFT_Q;
                                fpl_pkg::STEP_F4: r_f4 <= mul_p >> fpl_pkg::SHIFT_Q;
                                fpl_pkg::STEP_FB: r_fb <= mul_p >> fpl_pkg::SHIFT_Q;
                                default:          r_t  <= mul_p >> fpl_pkg::SHIFT_Q;
                            endcase
                            r_step  <= r_step + 5'd1;
                            r_state <= ST_MUL_GO;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIV_WAIT;
                        end
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_step  <= r_step + 5'd1;
                        r_state <= ST_MUL_GO;
                        case (r_step)
                            fpl_pkg::STEP_FBK:   r_v <= r_x - div_q;
                            fpl_pkg::STEP_GAIN:  r_v <= div_q;
                            fpl_pkg::STEP_CLIP0: r_c <= div_q;
                            fpl_pkg::STEP_CLIP1: r_c <= div_q;
                            fpl_pkg::STEP_LAST: begin
                                r_out[3] <= r_out[3] - div_q;
                                r_step   <= fpl_pkg::STEP_F2;
                                r_state  <= ST_DONE;
                            end
                            default: begin
                                if (pole_off[0]) begin
                                    // r_v carries the section input along the ladder
                                    r_out[k] <= pole_sum;
                                    r_in[k]  <= r_v;
                                    r_v      <= pole_sum;
                                end else begin
                                    r_t <= 32'(div_q);
                                end
                            end
                        endcase
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_out[3][fpl_pkg::SAMPLE_W-1:0];
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready)
            |=> (r_state == ST_MUL_GO && r_step == fpl_pkg::STEP_F2))
        else $error("accepted word did not start the sequence");
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (o_m_axis_tvalid && r_state == ST_IDLE))
        else $error("finished word not loaded into output register");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= fpl_pkg::STEP_LAST)
        else $error("step counter out of range");
    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");
`endif
endmodule

// ===== tb/tb_four_pole_ladder_lowpass_checker.sv =====
// checker for the four-pole ladder lowpass: watches both stream channels and the apb port,
// predicts each filtered word and compares it; depends on fpl_pkg
`timescale 1ns / 1ps
module tb_four_pole_ladder_lowpass_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    logic [14:0]       cut_q;
    logic [15:0]       res_q;
    logic signed [31:0] pole_out [4];
    logic signed [31:0] pole_in  [4];
    logic [15:0]       filtered_q [$];
    int                fails;
    int                pend;

    assign o_fail_count = fails;
    assign o_pending    = pend;

    function automatic logic signed [31:0] div_s(input logic signed [31:0] a);
        return a / $signed(fpl_pkg::SCALE_ONE);
    endfunction

    function automatic logic signed [31:0] mul_w(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [31:0] p;
        p = a * b;
        return p;
    endfunction

    task automatic filter_sample(input logic [15:0] smp);
        logic [31:0]        f, f2, f4, fb;
        logic signed [31:0] fi, v, src, nv, c, o4;
        f  = {17'd0, cut_q};
        f2 = (f * f) >> 15;
        f4 = (fpl_pkg::F4_GAIN * ((f2 * f2) >> 15)) >> 15;
        fi = $signed(fpl_pkg::SCALE_ONE) - $signed(f);
        fb = ({16'd0, res_q} * (fpl_pkg::SCALE_ONE - ((fpl_pkg::FB_DAMP * f2) >> 15))) >> 15;
        v = $signed({{16{smp[15]}}, smp}) - div_s(mul_w(pole_out[3], $signed(fb)));
        v = div_s(mul_w(v, $signed(f4)));
        src = v;
        for (int k = 0; k < 4; k++) begin
            nv = src + div_s(mul_w($signed(fpl_pkg::POLE_PREV_GAIN), pole_in[k]))
                 + div_s(mul_w(fi, pole_out[k]));
            pole_out[k] = nv;
            pole_in[k]  = src;
            src = nv;
        end
        o4 = pole_out[3];
        c  = div_s(mul_w(o4, o4));
        c  = div_s(mul_w(c, o4));
        c  = div_s(mul_w(c, $signed(fpl_pkg::CLIP_GAIN)));
        o4 = o4 - c;
        pole_out[3] = o4;
        filtered_q.push_back(o4[15:0]);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cut_q <= '0;
            res_q <= '0;
            for (int k = 0; k < 4; k++) begin
                pole_out[k] = 0;
                pole_in[k]  = 0;
            end
            filtered_q.delete();
            fails = 0;
            pend  = 0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == 3'd4 * fpl_pkg::REG_CUTOFF) cut_q <= pwdata[14:0];
                else if (paddr == 3'd4 * fpl_pkg::REG_RES) res_q <= pwdata[15:0];
            end
            if (i_s_axis_tvalid && i_s_axis_tready) filter_sample(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (filtered_q.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", i_m_axis_tdata));
                else begin
                    if (filtered_q[0] !== i_m_axis_tdata)
                        report_mismatch($sformatf("sample_out got %h want %h",
                                                  i_m_axis_tdata, filtered_q[0]));
                    void'(filtered_q.pop_front());
                end
            end
            pend = filtered_q.size();
        end
    end
endmodule

// ===== tb/tb_four_pole_ladder_lowpass_core.sv =====
// testbench top for four_pole_ladder_lowpass_core: clock, reset, apb writes, sample stimulus,
// receiver stalls and verdict; depends on fpl_pkg and the checker module
`timescale 1ns / 1ps
module tb_four_pole_ladder_lowpass_core;
    localparam int WORD_CYCLES = 1100;
    localparam int LIMIT = 8_000_000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [15:0] s_data = '0;   // sample_in
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_data;        // sample_out
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          cycle_cnt = 0;
    int          hold_off = 0;   // receiver long stall, in cycles
    bit          no_idle = 0;    // stretch with no idling on either side

    always #6 clk = ~clk;

    four_pole_ladder_lowpass_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_four_pole_ladder_lowpass_checker i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_valid), .i_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .i_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .i_m_axis_tdata(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("tb_four_pole_ladder_lowpass_core: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, plus the long hold-off counted here
    always @(posedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else
            m_ready <= no_idle || ($urandom_range(99) >= 20);
    end

    // apb write: setup cycle then access cycle
    task automatic write_reg(input logic reg_sel, input logic [31:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd4 * reg_sel; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // offer one sample, with a random idle gap before it; valid stays up after
    // the accept until the next sample or stop_input
    task automatic push_sample(input logic [15:0] smp);
        if (!no_idle && $urandom_range(99) < 20) begin
            s_valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < 20) @(posedge clk);
        end
        s_valid <= 1; s_data <= smp;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    // drop valid at the end of a burst
    task automatic stop_input();
        s_valid <= 0;
    endtask

    // drain every expected word, then let the block settle before a register write
    task automatic wait_idle();
        while (pending != 0) @(posedge clk);
        repeat (WORD_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [14:0] cut, input logic [15:0] res, input int n);
        wait_idle();
        write_reg(fpl_pkg::REG_CUTOFF, {17'h1ffff, cut});   // upper bits must be masked off
        write_reg(fpl_pkg::REG_RES, {16'hffff, res});
        for (int i = 0; i < n; i++) begin
            if (i % 4 == 0) push_sample($urandom_range(1) ? 16'h7fff : 16'h8000);
            else push_sample(16'($urandom));
        end
        stop_input();
    endtask

    initial begin
        logic [15:0] edges [6];
        edges = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'h5555};
        repeat (5) @(posedge clk);
        rst_n <= 1;
        // directed: reset coefficients, then extreme cutoff / resonance
        foreach (edges[i]) push_sample(edges[i]);
        stop_input();
        run_phase(15'h7fff, 16'hffff, 6);
        foreach (edges[i]) push_sample(edges[i]);
        stop_input();
        run_phase(15'd3000, 16'd40000, 6);
        // long receiver hold-off while the sender keeps offering
        hold_off <= 30 * WORD_CYCLES;
        for (int i = 0; i < 6; i++) push_sample(16'($urandom));
        stop_input();
        // sender pause until all words are back
        while (pending != 0) @(posedge clk);
        // random settings, one phase without idling
        for (int ph = 0; ph < 11; ph++) begin
            no_idle = (ph == 5);
            run_phase(15'($urandom), 16'($urandom), 48);
        end
        no_idle = 0;
        run_phase(15'd0, 16'd0, 10);
        while (pending != 0) @(posedge clk);
        repeat (WORD_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_four_pole_ladder_lowpass_core: done, clean");
        else
            $display("tb_four_pole_ladder_lowpass_core: done, errors");
        $finish;
    end
endmodule
